// ----- design/kabf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kabf_pkg
// shared types, constants and command codes of the angle/bias kalman filter
// ----------------------------------------------------------------------------
package kabf_pkg;

  localparam int unsigned NoiseW = 24;
  localparam int unsigned DataW  = 32;
  localparam int unsigned DtW    = 16;

  localparam logic [NoiseW-1:0] AngleNoiseRst = 24'd16777;
  localparam logic [NoiseW-1:0] BiasNoiseRst  = 24'd50332;
  localparam logic [NoiseW-1:0] MeasNoiseRst  = 24'd503316;

  // register indexes
  localparam logic [1:0] RegAngleNoise = 2'd0;
  localparam logic [1:0] RegBiasNoise  = 2'd1;
  localparam logic [1:0] RegMeasNoise  = 2'd2;

  localparam logic KindForce = 1'b1;

  // datapath steps issued by the controller
  typedef enum logic [3:0] {
    OpNone    = 4'd0,
    OpLoad    = 4'd1,
    OpForce   = 4'd2,
    OpPredA   = 4'd3,
    OpPredT   = 4'd4,
    OpPredP00 = 4'd5,
    OpPredP11 = 4'd6,
    OpDivInit = 4'd7,
    OpDivStep = 4'd8,
    OpDivEnd  = 4'd9,
    OpCorrA   = 4'd10,
    OpCorrB   = 4'd11,
    OpCorr00  = 4'd12,
    OpCorr01  = 4'd13,
    OpCorr10  = 4'd14,
    OpCorr11  = 4'd15
  } op_e;

  typedef struct packed {
    op_e  op;
    logic sel_k1;   // divide step works on the second gain
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647) r = 32'sh7fffffff;
    else if (x < -66'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  // round half up then arithmetic shift
  function automatic logic signed [65:0] rsh16(input logic signed [65:0] x);
    logic signed [65:0] v;
    v = x + 66'sd32768;
    return v >>> 16;
  endfunction

  function automatic logic signed [65:0] rsh24(input logic signed [65:0] x);
    logic signed [65:0] v;
    v = x + 66'sd8388608;
    return v >>> 24;
  endfunction

endpackage

// ----- design/kabf_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kabf_datapath
// state registers, one shared multiplier step per cycle and a restoring divider
// ----------------------------------------------------------------------------
module kabf_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  kabf_pkg::cmd_t            cmd_i,
  output kabf_pkg::sts_t            sts_o,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [23:0]               cfg_data_i,
  input  logic signed [31:0]        meas_i,
  input  logic signed [31:0]        gyro_i,
  input  logic [15:0]               dt_i,
  output logic signed [31:0]        angle_o
);

  logic [23:0] qa_q, qb_q, r_q;
  logic signed [31:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
  logic signed [31:0] meas_q, gyro_q, t_q, k0_q, k1_q, a00_q, a01_q, y_q;
  logic [15:0] dt_q;
  logic signed [31:0] ang_d, bias_d, p00_d, p01_d, p10_d, p11_d;
  logic signed [31:0] t_d, k0_d, k1_d, a00_d, a01_d, y_d;

  // divider: unsigned magnitude, 56-bit dividend, 34-bit divisor
  logic [55:0] dq_q, dq_d;
  logic [33:0] rem_q, rem_d;
  logic [33:0] dvs_q, dvs_d;
  logic        neg_q, neg_d, spos_q, spos_d;
  logic [5:0]  cnt_q, cnt_d;

  logic signed [33:0] s_w;
  logic signed [31:0] num_w;
  logic [34:0] trial_w;
  logic signed [57:0] quo_w;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_w;
  logic signed [31:0] rate_w;

  assign s_w    = 34'(p00_q) + $signed({10'd0, r_q});
  assign num_w  = cmd_i.sel_k1 ? p10_q : p00_q;
  assign trial_w = {rem_q, dq_q[55]} - {1'b0, dvs_q};
  assign quo_w  = neg_q ? -$signed({2'b0, dq_q}) : $signed({2'b0, dq_q});
  assign rate_w = kabf_pkg::sat32(66'(gyro_q) - 66'(bias_q));
  assign prod_w = mul_a * mul_b;
  assign sts_o.div_done = (cnt_q == 6'd56);
  assign angle_o = ang_q;

  // one multiplier operand pair per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      kabf_pkg::OpPredA:   begin mul_a = $signed({16'd0, dt_q}); mul_b = rate_w; end
      kabf_pkg::OpPredT:   begin mul_a = $signed({16'd0, dt_q}); mul_b = p11_q; end
      kabf_pkg::OpPredP11: begin mul_a = $signed({16'd0, dt_q}); mul_b = $signed({8'd0, qb_q}); end
      kabf_pkg::OpCorrA:   begin mul_a = k0_q; mul_b = y_q; end
      kabf_pkg::OpCorrB:   begin mul_a = k1_q; mul_b = y_q; end
      kabf_pkg::OpCorr00:  begin mul_a = k0_q; mul_b = a00_q; end
      kabf_pkg::OpCorr01:  begin mul_a = k0_q; mul_b = a01_q; end
      kabf_pkg::OpCorr10:  begin mul_a = k1_q; mul_b = a00_q; end
      kabf_pkg::OpCorr11:  begin mul_a = k1_q; mul_b = a01_q; end
      default: ;
    endcase
  end

  // step logic
  always_comb begin
    logic signed [35:0] inner;
    logic signed [52:0] pinner;
    logic signed [65:0] q66;
    inner = '0;
    pinner = '0;
    q66 = '0;
    ang_d = ang_q; bias_d = bias_q;
    p00_d = p00_q; p01_d = p01_q; p10_d = p10_q; p11_d = p11_q;
    t_d = t_q; k0_d = k0_q; k1_d = k1_q; a00_d = a00_q; a01_d = a01_q; y_d = y_q;
    dq_d = dq_q; rem_d = rem_q; dvs_d = dvs_q; neg_d = neg_q; spos_d = spos_q;
    cnt_d = cnt_q;
    unique case (cmd_i.op)
      kabf_pkg::OpForce:   ang_d = meas_q;
      kabf_pkg::OpPredA:   ang_d = kabf_pkg::sat32(66'(ang_q) + kabf_pkg::rsh16(66'(prod_w)));
      kabf_pkg::OpPredT:   t_d = kabf_pkg::sat32(kabf_pkg::rsh16(66'(prod_w)));
      kabf_pkg::OpPredP00: begin
        inner = 36'(t_q) - 36'(p01_q) - 36'(p10_q) + $signed({12'd0, qa_q});
        pinner = inner * $signed({1'b0, dt_q});
        p00_d = kabf_pkg::sat32(66'(p00_q) + kabf_pkg::rsh16(66'(pinner)));
        p01_d = kabf_pkg::sat32(66'(p01_q) - 66'(t_q));
        p10_d = kabf_pkg::sat32(66'(p10_q) - 66'(t_q));
      end
      kabf_pkg::OpPredP11: begin
        p11_d = kabf_pkg::sat32(66'(p11_q) + kabf_pkg::rsh16(66'(prod_w)));
        y_d = kabf_pkg::sat32(66'(meas_q) - 66'(ang_q));
      end
      kabf_pkg::OpDivInit: begin
        spos_d = (s_w > 34'sd0);
        dvs_d  = s_w;
        neg_d  = num_w[31];
        dq_d   = {(num_w[31] ? 32'(-num_w) : 32'(num_w)), 24'd0};
        rem_d  = '0;
        cnt_d  = '0;
      end
      kabf_pkg::OpDivStep: begin
        if (!trial_w[34]) begin
          rem_d = trial_w[33:0];
          dq_d  = {dq_q[54:0], 1'b1};
        end else begin
          rem_d = {rem_q[32:0], dq_q[55]};
          dq_d  = {dq_q[54:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
      end
      kabf_pkg::OpDivEnd: begin
        q66 = spos_q ? 66'(quo_w) : 66'sd0;
        if (cmd_i.sel_k1) k1_d = kabf_pkg::sat32(q66);
        else k0_d = kabf_pkg::sat32(q66);
        a00_d = p00_q;
        a01_d = p01_q;
      end
      kabf_pkg::OpCorrA:   ang_d = kabf_pkg::sat32(66'(ang_q) + kabf_pkg::rsh24(66'(prod_w)));
      kabf_pkg::OpCorrB:   bias_d = kabf_pkg::sat32(66'(bias_q) + kabf_pkg::rsh24(66'(prod_w)));
      kabf_pkg::OpCorr00:  p00_d = kabf_pkg::sat32(66'(p00_q) - kabf_pkg::rsh24(66'(prod_w)));
      kabf_pkg::OpCorr01:  p01_d = kabf_pkg::sat32(66'(p01_q) - kabf_pkg::rsh24(66'(prod_w)));
      kabf_pkg::OpCorr10:  p10_d = kabf_pkg::sat32(66'(p10_q) - kabf_pkg::rsh24(66'(prod_w)));
      kabf_pkg::OpCorr11:  p11_d = kabf_pkg::sat32(66'(p11_q) - kabf_pkg::rsh24(66'(prod_w)));
      default: ;
    endcase
  end

  // filter state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qa_q <= kabf_pkg::AngleNoiseRst;
      qb_q <= kabf_pkg::BiasNoiseRst;
      r_q  <= kabf_pkg::MeasNoiseRst;
      ang_q <= '0; bias_q <= '0;
      p00_q <= '0; p01_q <= '0; p10_q <= '0; p11_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          kabf_pkg::RegAngleNoise: qa_q <= cfg_data_i;
          kabf_pkg::RegBiasNoise:  qb_q <= cfg_data_i;
          kabf_pkg::RegMeasNoise:  r_q  <= cfg_data_i;
          default: ;
        endcase
      end
      ang_q <= ang_d; bias_q <= bias_d;
      p00_q <= p00_d; p01_q <= p01_d; p10_q <= p10_d; p11_q <= p11_d;
      cnt_q <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == kabf_pkg::OpLoad) begin
      meas_q <= meas_i;
      gyro_q <= gyro_i;
      dt_q   <= dt_i;
    end
    t_q <= t_d; k0_q <= k0_d; k1_q <= k1_d; a00_q <= a00_d; a01_q <= a01_d;
    y_q <= y_d; dq_q <= dq_d; rem_q <= rem_d; dvs_q <= dvs_d;
    neg_q <= neg_d; spos_q <= spos_d;
  end

endmodule

// ----- design/kabf_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kabf_ctrl
// sequencer: loads a force beat, else walks the datapath through predict, two divides and correct
// ----------------------------------------------------------------------------
module kabf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           kind_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output kabf_pkg::cmd_t cmd_o,
  input  kabf_pkg::sts_t sts_i
);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StPred  = 7'b0000010,
    StDiv0  = 7'b0000100,
    StDiv1  = 7'b0001000,
    StCorr  = 7'b0010000,
    StForce = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [2:0] sub_q, sub_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);

  always_comb begin
    state_d = state_q;
    sub_d   = sub_q;
    cmd_o.op = kabf_pkg::OpNone;
    cmd_o.sel_k1 = (state_q == StDiv1);
    unique case (state_q)
      StIdle: if (in_valid_i) begin
        cmd_o.op = kabf_pkg::OpLoad;
        state_d = (kind_i == kabf_pkg::KindForce) ? StForce : StPred;
        sub_d = '0;
      end
      StForce: begin
        cmd_o.op = kabf_pkg::OpForce;
        state_d = StOut;
      end
      StPred: begin
        unique case (sub_q)
          3'd0: cmd_o.op = kabf_pkg::OpPredA;
          3'd1: cmd_o.op = kabf_pkg::OpPredT;
          3'd2: cmd_o.op = kabf_pkg::OpPredP00;
          default: cmd_o.op = kabf_pkg::OpPredP11;
        endcase
        sub_d = sub_q + 3'd1;
        if (sub_q == 3'd3) begin
          state_d = StDiv0;
          sub_d = '0;
        end
      end
      StDiv0, StDiv1: begin
        if (sub_q == 3'd0) begin
          cmd_o.op = kabf_pkg::OpDivInit;
          sub_d = 3'd1;
        end else if (!sts_i.div_done) begin
          cmd_o.op = kabf_pkg::OpDivStep;
        end else begin
          cmd_o.op = kabf_pkg::OpDivEnd;
          sub_d = '0;
          state_d = (state_q == StDiv0) ? StDiv1 : StCorr;
        end
      end
      StCorr: begin
        unique case (sub_q)
          3'd0: cmd_o.op = kabf_pkg::OpCorrA;
          3'd1: cmd_o.op = kabf_pkg::OpCorrB;
          3'd2: cmd_o.op = kabf_pkg::OpCorr00;
          3'd3: cmd_o.op = kabf_pkg::OpCorr01;
          3'd4: cmd_o.op = kabf_pkg::OpCorr10;
          default: cmd_o.op = kabf_pkg::OpCorr11;
        endcase
        sub_d = sub_q + 3'd1;
        if (sub_q == 3'd5) state_d = StOut;
      end
      StOut: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      sub_q   <= '0;
    end else begin
      state_q <= state_d;
      sub_q   <= sub_d;
    end
  end

endmodule

// ----- design/kalman_angle_bias_filter.sv -----
`timescale 1ns / 1ps
// a normal input beat runs predict, two divides and correct before its result is offered;
// a force beat only loads the measured angle. One item at a time: a new beat is taken
// only after the result has been taken; two 56-step restoring divides set the pace
// reset: estimates and covariance cleared, noise registers to their defaults
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter
// two-state kalman filter for tilt angle and gyro bias, fixed point
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic signed [31:0] measured_angle_i,
  input  logic signed [31:0] gyro_rate_i,
  input  logic [15:0]        time_step_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] filtered_angle_o
);

  kabf_pkg::cmd_t cmd;
  kabf_pkg::sts_t sts;

  kabf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i,
    .out_valid_o, .out_ready_i, .cmd_o(cmd), .sts_i(sts)
  );

  kabf_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .meas_i(measured_angle_i), .gyro_i(gyro_rate_i), .dt_i(time_step_i),
    .angle_o(filtered_angle_o)
  );

endmodule
